// File: sv/m3inv_pkg.sv
// Package for the 3x3 matrix inverse block: payload structs and fixed widths.
// Used by every module of the block; depends on nothing.
package m3inv_pkg;

  typedef struct packed {
    logic signed [31:0] a00;
    logic signed [31:0] a01;
    logic signed [31:0] a02;
    logic signed [31:0] a10;
    logic signed [31:0] a11;
    logic signed [31:0] a12;
    logic signed [31:0] a20;
    logic signed [31:0] a21;
    logic signed [31:0] a22;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] b00;
    logic signed [31:0] b01;
    logic signed [31:0] b02;
    logic signed [31:0] b10;
    logic signed [31:0] b11;
    logic signed [31:0] b12;
    logic signed [31:0] b20;
    logic signed [31:0] b21;
    logic signed [31:0] b22;
    logic signed [31:0] determinant;
    logic               singular;
  } out_item_t;

  // Cross product terms are exact: 65 bits plus sign headroom.
  localparam int CrW  = 66;
  // Determinant is exact at 98 bits plus headroom.
  localparam int DetW = 100;
  // Divider width for magnitudes.
  localparam int QW   = 34;

  // Classified item handed from the front to the back part.
  typedef struct packed {
    logic [8:0][CrW-2:0] num_mag;
    logic [8:0]          num_neg;
    logic [DetW-1:0]     dmag;
    logic                dneg;
    logic signed [31:0]  det_sat;
    logic                singular;
  } job_t;

endpackage

// File: sv/m3inv_front.sv
// Front part: cross products, determinant, rounding and singular test.
// Depends on m3inv_pkg. Four register stages, one item per cycle.
module m3inv_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  acc,
  input  m3inv_pkg::in_item_t   item,
  input  logic [30:0]           thr,
  output logic                  job_vld,
  output m3inv_pkg::job_t       job
);
  import m3inv_pkg::*;

  localparam int Sh2 = 2 * FRAC_BITS;
  // Cross products are split into a signed high and an unsigned low half.
  localparam int LoW = CrW / 2;

  logic [3:0] vld_r;
  in_item_t   item_r;
  logic signed [CrW-1:0] cr_r [9];
  logic signed [DetW-1:0] det_r;
  logic signed [CrW-1:0] cr2_r [9];
  logic signed [CrW-1:0] cr3_r [9];
  logic signed [31:0] a_r [3];
  logic signed [CrW-1:0] pl_r [3];
  logic signed [CrW-2:0] ph_r [3];

  // Stage 1: register the incoming matrix.
  // Stage 2: cross products (two 32x32 products and a subtract each).
  // Stage 3: row 0 times column 0 of the cross products, as half products.
  // Stage 4: determinant from the half products.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], acc};
    end
    item_r <= item;
    cr_r[0] <= CrW'(item_r.a11 * item_r.a22) - CrW'(item_r.a12 * item_r.a21);
    cr_r[1] <= CrW'(item_r.a12 * item_r.a20) - CrW'(item_r.a10 * item_r.a22);
    cr_r[2] <= CrW'(item_r.a10 * item_r.a21) - CrW'(item_r.a11 * item_r.a20);
    cr_r[3] <= CrW'(item_r.a21 * item_r.a02) - CrW'(item_r.a22 * item_r.a01);
    cr_r[4] <= CrW'(item_r.a22 * item_r.a00) - CrW'(item_r.a20 * item_r.a02);
    cr_r[5] <= CrW'(item_r.a20 * item_r.a01) - CrW'(item_r.a21 * item_r.a00);
    cr_r[6] <= CrW'(item_r.a01 * item_r.a12) - CrW'(item_r.a02 * item_r.a11);
    cr_r[7] <= CrW'(item_r.a02 * item_r.a10) - CrW'(item_r.a00 * item_r.a12);
    cr_r[8] <= CrW'(item_r.a00 * item_r.a11) - CrW'(item_r.a01 * item_r.a10);
    a_r[0] <= item_r.a00;
    a_r[1] <= item_r.a01;
    a_r[2] <= item_r.a02;
    for (int i = 0; i < 3; i++) begin
      pl_r[i] <= CrW'(a_r[i] * $signed({1'b0, cr_r[i][LoW-1:0]}));
      ph_r[i] <= (CrW-1)'(a_r[i] * $signed(cr_r[i][CrW-1:LoW]));
    end
    det_r <= ((DetW'(ph_r[0]) + DetW'(ph_r[1]) + DetW'(ph_r[2])) << LoW)
           + DetW'(pl_r[0]) + DetW'(pl_r[1]) + DetW'(pl_r[2]);
    cr2_r <= cr_r;
    cr3_r <= cr2_r;
  end

  // Rounding and classification on the stage 4 outputs.
  logic            dneg;
  logic [DetW-1:0] dmag;
  logic [DetW-1:0] dround;
  logic            sing;

  always_comb begin
    dneg   = det_r[DetW-1];
    dmag   = dneg ? DetW'(-det_r) : DetW'(det_r);
    dround = (dmag + (DetW'(1) << (Sh2 - 1))) >> Sh2;
    sing   = (dround <= DetW'(thr));
    job.dmag     = dmag;
    job.dneg     = dneg;
    job.singular = sing;
    if (dneg) begin
      job.det_sat = (dround > DetW'(33'h080000000)) ? 32'sh80000000
                                                    : 32'(-dround[31:0]);
    end else begin
      job.det_sat = (dround > DetW'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : 32'(dround[31:0]);
    end
    // Output element (r,c) takes cross product term of column c, row r.
    for (int k = 0; k < 9; k++) begin
      logic signed [CrW-1:0] n;
      n = cr3_r[(k % 3) * 3 + (k / 3)];
      job.num_neg[k] = n[CrW-1];
      job.num_mag[k] = n[CrW-1] ? (CrW-1)'(-n) : (CrW-1)'(n);
    end
  end

  assign job_vld = vld_r[3];

endmodule

// File: sv/m3inv_queue.sv
// Short single-entry register queue between front and back parts.
// Depends on m3inv_pkg. Both sides run every cycle, so it never fills.
module m3inv_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_vld,
  input  m3inv_pkg::job_t   wr_job,
  output logic              rd_vld,
  output m3inv_pkg::job_t   rd_job
);
  import m3inv_pkg::*;

  logic vld_r;
  job_t job_r;

  // One register stage that decouples the two timing domains of logic.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= wr_vld;
    end
    job_r <= wr_job;
  end

  assign rd_vld = vld_r;
  assign rd_job = job_r;

endmodule

// File: sv/m3inv_back.sv
// Back part: nine pipelined restoring dividers, one quotient bit per stage.
// Depends on m3inv_pkg. All divider stages are registered, one item per cycle.
module m3inv_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  job_vld,
  input  m3inv_pkg::job_t       job,
  output logic                  out_strobe,
  output m3inv_pkg::out_item_t  out_item
);
  import m3inv_pkg::*;

  localparam int Sh2 = 2 * FRAC_BITS;
  // Numerator (2*num << Sh2) + dmag; quotient bits above QW saturate anyway.
  localparam int NW = CrW + Sh2 + 1;
  localparam int RW = DetW + 2;
  localparam int Steps = QW;

  typedef struct packed {
    logic [8:0][NW-1:0] num;
    logic [8:0][RW-1:0] rem;
    logic [8:0][QW-1:0] quo;
    logic [8:0]         ovf;
    logic [8:0]         neg;
    logic [RW-1:0]      dv;
    logic signed [31:0] det_sat;
    logic               singular;
  } stg_t;

  logic [Steps:0] vld_r;
  stg_t           stg_r [Steps+1];
  stg_t           stg_nxt [Steps+1];
  stg_t           st0;

  // Set up: numerator = 2*|num|*2^Sh2 + |det|; divisor = 2*|det|.
  // Any quotient bits above QW-1 flag overflow, detected up front by compare.
  always_comb begin
    st0 = '0;
    st0.dv       = RW'({job.dmag, 1'b0});
    st0.det_sat  = job.det_sat;
    st0.singular = job.singular;
    for (int k = 0; k < 9; k++) begin
      logic [NW+QW-1:0] n;
      n = ((NW+QW)'(job.num_mag[k]) << (Sh2 + 1)) + (NW+QW)'(job.dmag);
      st0.num[k] = NW'(n);
      st0.neg[k] = job.num_neg[k] ^ job.dneg;
      // Overflow if n >= dv << QW.
      st0.ovf[k] = ((NW+QW+RW)'(n) >= ((NW+QW+RW)'(st0.dv) << QW));
    end
  end

  // Each stage brings down one numerator bit, from the bit at QW-1 down.
  // The first stage starts from the numerator bits above QW positions,
  // which stay below the divisor once the quotient is known not to overflow.
  always_comb begin
    stg_nxt[0] = st0;
    for (int s = 0; s < Steps; s++) begin
      stg_nxt[s+1] = stg_r[s];
      for (int k = 0; k < 9; k++) begin
        logic [RW:0] t;
        logic [RW+NW-1:0] base;
        base = (RW+NW)'(stg_r[s].num[k]) >> QW;
        if (s == 0) begin
          t = {base[RW-1:0], stg_r[s].num[k][QW-1]};
        end else begin
          t = {stg_r[s].rem[k], stg_r[s].num[k][QW-1-s]};
        end
        if (t >= (RW+1)'(stg_r[s].dv)) begin
          stg_nxt[s+1].rem[k] = RW'(t - (RW+1)'(stg_r[s].dv));
          stg_nxt[s+1].quo[k] = {stg_r[s].quo[k][QW-2:0], 1'b1};
        end else begin
          stg_nxt[s+1].rem[k] = RW'(t);
          stg_nxt[s+1].quo[k] = {stg_r[s].quo[k][QW-2:0], 1'b0};
        end
      end
    end
  end

  // Divider pipeline registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[Steps-1:0], job_vld};
    end
    stg_r <= stg_nxt;
  end

  // Saturate and zero on singular.
  logic [8:0][31:0] b;
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      logic [QW-1:0] q;
      q = stg_r[Steps].quo[k];
      if (stg_r[Steps].singular) begin
        b[k] = '0;
      end else if (stg_r[Steps].neg[k]) begin
        b[k] = (stg_r[Steps].ovf[k] || q > QW'(33'h080000000)) ? 32'h80000000
                                                                : 32'(-q);
      end else begin
        b[k] = (stg_r[Steps].ovf[k] || q > QW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF
                                                               : 32'(q);
      end
    end
    out_item.b00 = b[0];
    out_item.b01 = b[1];
    out_item.b02 = b[2];
    out_item.b10 = b[3];
    out_item.b11 = b[4];
    out_item.b12 = b[5];
    out_item.b20 = b[6];
    out_item.b21 = b[7];
    out_item.b22 = b[8];
    out_item.determinant = stg_r[Steps].det_sat;
    out_item.singular    = stg_r[Steps].singular;
  end

  assign out_strobe = vld_r[Steps];

endmodule

// File: sv/matrix3x3_inverse.sv
// Top level of the 3x3 matrix inverse block.
// Depends on m3inv_pkg, m3inv_front, m3inv_queue and m3inv_back.
//
// Usage: drive a matrix on in_item and raise start; it is taken at any
// clock edge with start high, and busy is always low, so one matrix may
// enter every cycle. The result leaves on out_item with out_strobe high
// for one cycle, after 40 register stages: 4 front stages, 1 queue stage,
// 35 divider stages, one stage per quotient bit of the nine pipelined
// restoring dividers plus setup.
// Throughput is one item per cycle. The user writes the singular threshold
// through cfg_we/cfg_wdata only while the block is idle; the block does
// not enforce this. Reset sets it to 1 and drops every item in flight.
// The receiver cannot stall: each result is shown for one cycle only.
module matrix3x3_inverse #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  m3inv_pkg::in_item_t   in_item,
  input  logic                  cfg_we,
  input  logic [30:0]           cfg_wdata,
  output logic                  out_strobe,
  output m3inv_pkg::out_item_t  out_item
);
  import m3inv_pkg::*;

  logic [30:0] thr_r;
  logic        f_vld;
  job_t        f_job;
  logic        q_vld;
  job_t        q_job;

  // Threshold register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 31'd1;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  m3inv_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .acc(start && !busy), .item(in_item),
    .thr(thr_r), .job_vld(f_vld), .job(f_job)
  );

  m3inv_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_vld(f_vld), .wr_job(f_job),
    .rd_vld(q_vld), .rd_job(q_job)
  );

  m3inv_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .job_vld(q_vld), .job(q_job),
    .out_strobe(out_strobe), .out_item(out_item)
  );

endmodule

// File: bench/matrix3x3_inverse_tb.sv
// Testbench for the 3x3 matrix inverse block: directed and random matrices
// under several singular thresholds, checked against a built-in predictor.
// Depends on m3inv_pkg and matrix3x3_inverse.
module matrix3x3_inverse_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import m3inv_pkg::*;

  localparam int FRAC = 16;
  localparam int DRAIN_CYCLES = 45;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic cfg_we = 1'b0;
  logic [30:0] cfg_wdata = '0;
  logic out_strobe;
  out_item_t out_item;

  in_item_t matrices_q[$];
  out_item_t inverses_q[$];
  logic [30:0] thr_shadow = 31'd1;
  bit no_gaps = 1'b0;
  bit failed = 1'b0;
  bit taken = 1'b0;
  int gap_left = 0;

  matrix3x3_inverse #(.FRAC_BITS(FRAC)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .out_strobe(out_strobe),
    .out_item(out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Saturate a sign-magnitude value to 32-bit two's complement.
  function automatic logic [31:0] clamp32(logic [127:0] mag, bit neg);
    if (neg) begin
      if (mag > 128'h8000_0000) return 32'h8000_0000;
      return 32'(-mag);
    end
    if (mag > 128'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  // Exact adjugate and determinant, then rounded quotients per element.
  function automatic out_item_t inverse_of(in_item_t m, logic [30:0] thr);
    logic signed [127:0] a[3][3];
    logic signed [127:0] cr[3][3];
    logic signed [127:0] det;
    logic [127:0] dmag, dround, nmag, q;
    logic [31:0] b[9];
    bit dneg, sing, nneg;
    int u, v;
    out_item_t res;
    a[0][0] = m.a00; a[0][1] = m.a01; a[0][2] = m.a02;
    a[1][0] = m.a10; a[1][1] = m.a11; a[1][2] = m.a12;
    a[2][0] = m.a20; a[2][1] = m.a21; a[2][2] = m.a22;
    // Column k of the adjugate is the cross product of the other two rows.
    for (int k = 0; k < 3; k++) begin
      u = (k + 1) % 3;
      v = (k + 2) % 3;
      cr[k][0] = a[u][1] * a[v][2] - a[u][2] * a[v][1];
      cr[k][1] = a[u][2] * a[v][0] - a[u][0] * a[v][2];
      cr[k][2] = a[u][0] * a[v][1] - a[u][1] * a[v][0];
    end
    det = a[0][0] * cr[0][0] + a[0][1] * cr[0][1] + a[0][2] * cr[0][2];
    dneg = det[127];
    dmag = dneg ? -det : det;
    dround = (dmag + (128'd1 << (2 * FRAC - 1))) >> (2 * FRAC);
    sing = (dround <= {97'd0, thr});
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        b[r * 3 + c] = '0;
        if (!sing) begin
          nneg = cr[c][r][127];
          nmag = nneg ? -cr[c][r] : cr[c][r];
          q = ((nmag << (2 * FRAC + 1)) + dmag) / (dmag << 1);
          b[r * 3 + c] = clamp32(q, nneg != dneg);
        end
      end
    end
    res.b00 = b[0]; res.b01 = b[1]; res.b02 = b[2];
    res.b10 = b[3]; res.b11 = b[4]; res.b12 = b[5];
    res.b20 = b[6]; res.b21 = b[7]; res.b22 = b[8];
    res.determinant = clamp32(dround, dneg);
    res.singular = sing;
    return res;
  endfunction

  function automatic bit same_field(string name, logic [31:0] e, logic [31:0] g);
    if (e !== g) begin
      $error("%s: expected %h, got %h", name, e, g);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Driver: offer queued matrices at the falling edge, with random gaps.
  always @(negedge clk) begin
    if (rst_n) begin
      if (start && !taken) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (!no_gaps && $urandom_range(0, 9) == 0) begin
        gap_left <= $urandom_range(0, 14);
        start <= 1'b0;
      end else if (matrices_q.size() > 0) begin
        in_item <= matrices_q.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check each strobed result, then predict for an accepted item.
  always @(posedge clk) begin
    out_item_t e;
    bit ok;
    if (rst_n && out_strobe) begin
      if (inverses_q.size() == 0) begin
        $error("result arrived with no matrix outstanding");
        failed = 1'b1;
      end else begin
        e = inverses_q.pop_front();
        ok = 1'b1;
        ok &= same_field("b00", e.b00, out_item.b00);
        ok &= same_field("b01", e.b01, out_item.b01);
        ok &= same_field("b02", e.b02, out_item.b02);
        ok &= same_field("b10", e.b10, out_item.b10);
        ok &= same_field("b11", e.b11, out_item.b11);
        ok &= same_field("b12", e.b12, out_item.b12);
        ok &= same_field("b20", e.b20, out_item.b20);
        ok &= same_field("b21", e.b21, out_item.b21);
        ok &= same_field("b22", e.b22, out_item.b22);
        ok &= same_field("determinant", e.determinant, out_item.determinant);
        ok &= same_field("singular", 32'(e.singular), 32'(out_item.singular));
        if (!ok) failed = 1'b1;
      end
    end
    taken = rst_n && start && !busy;
    if (taken) inverses_q.push_back(inverse_of(in_item, thr_shadow));
  end

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 16 << FRAC)) - (8 << FRAC));
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'd0;
          3: return 32'd1;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return 32'($signed($urandom_range(0, 1 << FRAC)) - (1 << (FRAC - 1)));
    endcase
  endfunction

  function automatic in_item_t rand_matrix();
    in_item_t m;
    m = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
         rand_elem(), rand_elem(), rand_elem(), rand_elem()};
    // Some matrices are made singular by a repeated or zero row.
    case ($urandom_range(0, 9))
      0: {m.a20, m.a21, m.a22} = {m.a00, m.a01, m.a02};
      1: {m.a10, m.a11, m.a12} = '0;
      default: ;
    endcase
    return m;
  endfunction

  function automatic in_item_t diag(logic [31:0] d0, logic [31:0] d1, logic [31:0] d2);
    in_item_t m;
    m = '0;
    m.a00 = d0; m.a11 = d1; m.a22 = d2;
    return m;
  endfunction

  task automatic write_threshold(logic [30:0] thr);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= thr;
    thr_shadow = thr;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (matrices_q.size() > 0 || start || inverses_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(int n);
    repeat (n) matrices_q.push_back(rand_matrix());
    wait_idle();
  endtask

  // Stimulus: directed cases, then random phases at several thresholds.
  initial begin
    in_item_t m;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    matrices_q.push_back(diag(32'h1_0000, 32'h1_0000, 32'h1_0000));
    matrices_q.push_back('0);
    matrices_q.push_back({9{32'h7FFF_FFFF}});
    matrices_q.push_back({9{32'h8000_0000}});
    matrices_q.push_back(diag(32'h2_0000, 32'h0_8000, 32'hFFFF_0000));
    matrices_q.push_back(diag(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    matrices_q.push_back(diag(32'd1, 32'd1, 32'd1));
    matrices_q.push_back(diag(32'h100, 32'h100, 32'h100));
    matrices_q.push_back(diag(32'h1_0000, 32'h1_0000, 32'd1));
    matrices_q.push_back(diag(32'h1_0000, 32'h1_0000, 32'd2));
    matrices_q.push_back(diag(32'h1_0000, 32'h1_0000, 32'd3));
    matrices_q.push_back(diag(32'h100_0000, 32'h100_0000, 32'h100_0000));
    m = {32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h4_0000, 32'h5_0000,
         32'h6_0000, 32'h7_0000, 32'h8_0000, 32'hA_0000};
    matrices_q.push_back(m);
    m = {32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h1_0000, 32'h2_0000,
         32'h3_0000, 32'h7_0000, 32'h8_0000, 32'hA_0000};
    matrices_q.push_back(m);
    m = {32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'd0,
         32'h8000_0000, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF};
    matrices_q.push_back(m);
    m = {32'h0_8000, 32'hFFFF_8000, 32'h0_0001, 32'hFFFF_FFFF, 32'h0_8000,
         32'h1_0000, 32'h0_4000, 32'hFFFF_C000, 32'h0_8000};
    matrices_q.push_back(m);
    wait_idle();
    run_random(500);
    write_threshold(31'd0);
    matrices_q.push_back(diag(32'h1_0000, 32'h1_0000, 32'd1));
    matrices_q.push_back('0);
    run_random(300);
    write_threshold(31'h7FFF_FFFF);
    matrices_q.push_back({9{32'h7FFF_FFFF}});
    matrices_q.push_back(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    run_random(250);
    write_threshold(31'($urandom));
    run_random(250);
    write_threshold(31'(1 << FRAC));
    no_gaps = 1'b1;
    run_random(250);
    if (inverses_q.size() > 0) begin
      $error("%0d results never arrived", inverses_q.size());
      failed = 1'b1;
    end
    if (!failed) begin
      $display("** matrix3x3_inverse: PASSED **");
    end else begin
      $display("** matrix3x3_inverse: FAILED **");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("** matrix3x3_inverse: FAILED **");
    $finish;
  end

endmodule
